// ===== design/indexed_list_store_assert.svh =====
// Assertion macros for the indexed list store.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ILS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed_list_store: same-cycle check failed");

`define ILS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed_list_store: next-cycle check failed");

`else

`define ILS_ASSERT_SAME(lbl, ante, cons)

`define ILS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/ils_pkg.sv =====
`default_nettype none

package ils_pkg;

   localparam int unsigned KIND_W  = 3;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned STATUS_W = 2;

   localparam logic [DATA_W-1:0] NO_VALUE = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ     = 3'd0,
      KIND_INS_HEAD = 3'd1,
      KIND_INS_TAIL = 3'd2,
      KIND_INS_POS  = 3'd3,
      KIND_DELETE   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic              rd;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== design/ils_req_if.sv =====
`default_nettype none

interface ils_req_if;
   import ils_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [POS_W-1:0]           position;
   logic signed [DATA_W-1:0]   new_value;

   modport source (output valid, output kind, output position, output new_value,
                   input ready);
   modport sink   (input valid, input kind, input position, input new_value,
                   output ready);
endinterface

`default_nettype wire

// ===== design/ils_rsp_if.sv =====
`default_nettype none

interface ils_rsp_if;
   import ils_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   read_value;
   logic [COUNT_W-1:0]         entry_count;

   modport source (output valid, output status, output read_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== design/indexed_list_store.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells, one entry
// per cell. Each request beat reads, inserts (head, tail or before a position) or deletes
// one entry and returns one response beat with status, read value (all ones unless a read
// succeeds) and the entry count afterwards. An accepted request is registered in IDLE,
// decoded against the entry count; in APPLY every cell shifts or loads in parallel; and in
// GATHER the read value is gathered from the row and loaded into the response register. A
// new request is taken only in IDLE, once the previous response is loaded, while that
// response may still wait for its sink; no request is taken while one is in APPLY or
// GATHER. A response still waiting when the next one is gathered holds that request in
// its gather cycle until the sink takes the earlier beat. Entries need no clearing after
// reset.
`default_nettype none

`include "indexed_list_store_assert.svh"

module indexed_list_store #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   ils_req_if.sink    req_bus,
   ils_rsp_if.source  rsp_bus
);
   import ils_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      IDLE,
      APPLY,
      GATHER
   } state_type;

   state_type            state_ff;
   cell_cmd_type         cmd_ff;
   cell_cmd_type         cmd_in;
   logic [PW-1:0]        pos_ff;
   logic [PW-1:0]        at_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   status_type           status_ff;
   status_type           status_in;
   logic                 read_ok_ff;
   logic                 read_ok_in;
   logic                 ins_req;
   logic                 full;
   logic                 ins_full;
   logic [PW-1:0]        pos_ext;
   logic [PW-1:0]        cnt_ext;
   logic                 accept;
   logic                 load;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DATA_W-1:0]    rsp_value_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [DATA_W-1:0]    cell_data [CAPACITY];
   logic [DATA_W-1:0]    cell_rd   [CAPACITY];
   logic [DATA_W-1:0]    gathered;

   assign accept  = req_bus.valid && req_bus.ready;
   assign load    = (state_ff == GATHER) && (!rsp_valid_ff || rsp_bus.ready);
   assign pos_ext = PW'(req_bus.position);
   assign cnt_ext = PW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));
   assign ins_full = accept && full &&
                     (req_bus.kind == KIND_INS_HEAD || req_bus.kind == KIND_INS_TAIL);

   always_comb begin
      cmd_in       = '0;
      cmd_in.value = req_bus.new_value;
      at_in        = pos_ext;
      status_in    = ST_OK;
      read_ok_in   = 1'b0;
      count_in     = count_ff;
      ins_req      = 1'b0;
      unique case (kind_type'(req_bus.kind))
         KIND_READ: begin
            if (pos_ext < cnt_ext) begin
               cmd_in.rd  = 1'b1;
               read_ok_in = 1'b1;
            end else begin
               status_in = ST_BADPOS;
            end
         end
         KIND_INS_HEAD: begin
            ins_req = 1'b1;
            at_in   = '0;
         end
         KIND_INS_TAIL: begin
            ins_req = 1'b1;
            at_in   = cnt_ext;
         end
         KIND_INS_POS: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_BADPOS;
            end else begin
               ins_req = 1'b1;
            end
         end
         KIND_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_BADPOS;
            end else begin
               cmd_in.del = 1'b1;
               count_in   = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
      if (ins_req) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            cmd_in.ins = 1'b1;
            count_in   = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cmd_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff <= (state_ff == IDLE && accept) ? cmd_in : '0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  pos_ff     <= at_in;
                  count_ff   <= count_in;
                  status_ff  <= status_in;
                  read_ok_ff <= read_ok_in;
                  state_ff   <= APPLY;
               end
            end
            APPLY: begin
               state_ff <= GATHER;
            end
            GATHER: begin
               if (load) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
         if (load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_ff;
            rsp_value_ff  <= read_ok_ff ? gathered : NO_VALUE;
            rsp_count_ff  <= COUNT_W'(count_ff);
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ils_cell #(
         .INDEX (i),
         .PW    (PW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd_ff),
         .pos        (pos_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   always_comb begin
      gathered = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         gathered = gathered | cell_rd[i];
      end
   end

   assign req_bus.ready       = (state_ff == IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.read_value  = rsp_value_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

   `ILS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY))
   `ILS_ASSERT_SAME(a_cmd_single, 1'b1, $onehot0({cmd_ff.ins, cmd_ff.del, cmd_ff.rd}))
   `ILS_ASSERT_NEXT(a_full_keeps, ins_full, count_ff == $past(count_ff) && status_ff == ST_FULL)
   `ILS_ASSERT_NEXT(a_load_shows, load, rsp_valid_ff && state_ff == IDLE)
   `ILS_ASSERT_SAME(a_cmd_idle, state_ff != APPLY, !(cmd_ff.ins || cmd_ff.del || cmd_ff.rd))

endmodule

`default_nettype wire

// ===== design/ils_cell.sv =====
`default_nettype none

module ils_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned PW    = 7
) (
   input  logic                        clock,
   input  ils_pkg::cell_cmd_type       cmd,
   input  logic [PW-1:0]               pos,
   input  logic [ils_pkg::DATA_W-1:0]  left_data,
   input  logic [ils_pkg::DATA_W-1:0]  right_data,
   output logic [ils_pkg::DATA_W-1:0]  data,
   output logic [ils_pkg::DATA_W-1:0]  rd_data
);
   import ils_pkg::*;

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [DATA_W-1:0] rd_ff;
   logic              at_pos;
   logic              below_pos;

   assign at_pos    = (pos == IDX);
   assign below_pos = (IDX < pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (at_pos) begin
            data_in = cmd.value;
         end else if (!below_pos) begin
            data_in = left_data;
         end
      end else if (cmd.del) begin
         if (!below_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (cmd.rd) begin
         rd_ff <= at_pos ? data_ff : '0;
      end
   end

   assign data    = data_ff;
   assign rd_data = rd_ff;

endmodule

`default_nettype wire
